FILE: sv/neighbor_link_stats_table_assert.svh
// Assertion macros for the neighbour link statistics table.
// Used by the port checker; no other dependencies.
`ifndef NEIGHBOR_LINK_STATS_TABLE_ASSERT_SVH
`define NEIGHBOR_LINK_STATS_TABLE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define NLST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("nlst check failed");
// Next-cycle implication checked outside reset.
`define NLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("nlst check failed");
`endif

FILE: sv/nlst_pkg.sv
// Shared types and constants for the neighbour link statistics table.
// No dependencies.
`default_nettype none
package nlst_pkg;
	localparam int ENTRIES = 32;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_UPDATED = 3'd0,
		ST_ADDED   = 3'd1,
		ST_LOW_RSSI = 3'd2,
		ST_FULL    = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_BCAST   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_BAD_MAX_RSSI = 3'd0,
		REG_GOOD_MIN_RSSI = 3'd1,
		REG_STAB_THR = 3'd2,
		REG_MHRI = 3'd3,
		REG_DLC = 3'd4,
		REG_MIN_TX = 3'd5,
		REG_DEF_JP = 3'd6
	} reg_idx_t;

	// Divider handshake
	typedef struct packed {
		logic start;
		logic [39:0] dividend;
		logic [7:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

FILE: sv/nlst_div.sv
// Restoring radix-2 divider for the link cost quotient, one bit a cycle.
// Depends on nlst_pkg.
`default_nettype none
module nlst_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire nlst_pkg::div_req_t req,
	output logic done,
	output logic [39:0] quotient
);
	import nlst_pkg::*;

	logic [39:0] quo_q;
	logic [7:0] rem_q;
	logic [7:0] dvs_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [9:0] trial;
	logic [8:0] shifted;

	// The remainder stays below the divisor, so eight bits hold it; the
	// shifted partial remainder needs nine and the trial a sign bit on top
	assign shifted = {rem_q, quo_q[39]};
	assign trial = {1'b0, shifted} - {2'b0, dvs_q};

	// Shift one dividend bit per cycle into the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd40;
				quo_q <= req.dividend;
				rem_q <= '0;
				dvs_q <= req.divisor;
			end else if (busy_q) begin
				if (!trial[9]) begin
					rem_q <= trial[7:0];
					quo_q <= {quo_q[38:0], 1'b1};
				end else begin
					rem_q <= shifted[7:0];
					quo_q <= {quo_q[38:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quotient = quo_q;
endmodule
`default_nettype wire

FILE: sv/neighbor_link_stats_table.sv
// Neighbour link statistics table, top level.
// Depends on nlst_pkg and nlst_div.
//
// Usage: raise start with one event (cmd 0 receive, 1 transmit) while busy is
// low; the transaction is taken at that edge and busy rises. A sequencer walks
// the table one row a cycle to find the matching address and the lowest free
// row, applies the update, then forms the OF0 link cost with a shared 16x11
// multiplier and a one-bit-a-cycle divider when the row has acknowledgements.
// The result appears for one cycle with done high; the receiver cannot hold
// it off. An event that touches no row goes from the row search straight to
// the result; a touched row passes the update and the two multiplier steps,
// and with acks also the divider, before done rises. Busy is already low in
// the done cycle, so the next event may be taken at the edge that ends it.
// Configuration writes on cfg_valid/cfg_ready are taken whenever the table is
// idle; cfg_ready is high whenever busy is low.
// Reset invalidates all rows and loads the register defaults; no clearing pass.
`default_nettype none
module neighbor_link_stats_table (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic cmd,
	input  wire logic [63:0] addr,
	input  wire logic signed [7:0] rssi,
	input  wire logic [39:0] timestamp,
	input  wire logic join_prio_present,
	input  wire logic [7:0] join_prio,
	input  wire logic insecure,
	input  wire logic [7:0] tx_attempts,
	input  wire logic acked,
	input  wire logic is_broadcast,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [10:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [4:0] entry_index,
	output logic entry_stable,
	output logic [15:0] link_cost,
	output logic entry_blacklisted,
	output logic [7:0] tx_count_out,
	output logic [7:0] ack_count_out
);
	import nlst_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_COST, S_MUL1, S_MUL2, S_DIV, S_DIVWAIT, S_FINISH
	} state_t;

	// Configuration registers
	logic signed [7:0] bad_max_q, good_min_q;
	logic [7:0] stab_thr_q, min_tx_q, def_jp_q;
	logic [10:0] mhri_q;
	logic [5:0] dlc_q;

	// Row state
	logic [ENTRIES-1:0] valid_q, stable_q, insec_q, black_q;
	logic [63:0] addr_q [ENTRIES];
	logic [7:0] stab_cnt_q [ENTRIES];
	logic [7:0] last_rssi_q [ENTRIES];
	logic [7:0] rx_q [ENTRIES];
	logic [7:0] tx_q [ENTRIES];
	logic [7:0] ack_q [ENTRIES];
	logic [7:0] wrap_q [ENTRIES];
	logic [39:0] heard_q [ENTRIES];
	logic [7:0] jp_q [ENTRIES];

	// Latched event
	logic cmd_q, jpp_q, insecure_q, acked_q, bcast_q;
	logic [63:0] ev_addr_q;
	logic signed [7:0] rssi_q;
	logic [39:0] ts_q;
	logic [7:0] jp_in_q, att_q;

	state_t state_q;
	logic [CNT_W-1:0] scan_q;
	logic hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, row_q;
	logic row_ok_q;
	status_t st_q;
	logic [7:0] tx_r_q, ack_r_q;
	logic [31:0] prod_q;
	logic signed [31:0] dflt_q;
	logic [39:0] sub_q;
	div_req_t dreq;
	logic ddone;
	logic [39:0] dquo;

	logic [IDX_W-1:0] scan_idx;
	assign scan_idx = scan_q[IDX_W-1:0];

	// Shared multiplier
	logic [15:0] mul_a;
	logic [31:0] mul_p;
	assign mul_p = {16'd0, mul_a} * {21'd0, mhri_q};

	nlst_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quotient(dquo));

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;

	logic [8:0] txsum;
	logic [7:0] tx_cur, ack_cur, cnt_inc;
	logic [15:0] tx3;
	logic [40:0] ddiff;
	logic [15:0] div_cost;
	logic flip_cond;
	assign tx_cur = tx_q[row_q];
	assign ack_cur = ack_q[row_q];
	assign txsum = {1'b0, tx_cur} + {1'b0, att_q};
	assign cnt_inc = stab_cnt_q[row_q] + 8'd1;
	assign flip_cond = stable_q[row_q] ? (rssi_q < good_min_q) : (rssi_q > bad_max_q);
	assign tx3 = {8'd0, tx_r_q} * 16'd3;
	assign ddiff = {1'b0, dquo} - {1'b0, sub_q};

	// Clamp the quotient minus the offset to the 16-bit cost range
	assign div_cost = ddiff[40] ? 16'd0 :
		(ddiff[39:26] != '0) ? 16'hFFFF : ddiff[25:10];

	// Multiplier operand: default cost factor, then the row's factor
	always_comb begin
		case (state_q)
			S_MUL1: mul_a = {10'd0, dlc_q} * 16'd3 - 16'd2;
			S_MUL2: mul_a = (ack_r_q == 8'd0) ? tx3 - 16'd2 : tx3;
			default: mul_a = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bad_max_q <= -8'sd70;
			good_min_q <= -8'sd90;
			stab_thr_q <= 8'd3;
			mhri_q <= 11'd256;
			dlc_q <= 6'd15;
			min_tx_q <= 8'd16;
			def_jp_q <= 8'd255;
			valid_q <= '0;
			black_q <= '0;
			done <= 1'b0;
			dreq.start <= 1'b0;
		end else begin
			done <= 1'b0;
			dreq.start <= 1'b0;
			// Take configuration transactions
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BAD_MAX_RSSI: bad_max_q <= cfg_data[7:0];
					REG_GOOD_MIN_RSSI: good_min_q <= cfg_data[7:0];
					REG_STAB_THR: stab_thr_q <= cfg_data[7:0];
					REG_MHRI: mhri_q <= cfg_data;
					REG_DLC: dlc_q <= cfg_data[5:0];
					REG_MIN_TX: min_tx_q <= cfg_data[7:0];
					REG_DEF_JP: def_jp_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd; ev_addr_q <= addr; rssi_q <= rssi;
						ts_q <= timestamp; jpp_q <= join_prio_present;
						jp_in_q <= join_prio; insecure_q <= insecure;
						att_q <= tx_attempts; acked_q <= acked;
						bcast_q <= is_broadcast;
						scan_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				// Walk rows one a cycle
				S_SCAN: begin
					if (valid_q[scan_idx] && addr_q[scan_idx] == ev_addr_q && !hit_q) begin
						hit_q <= 1'b1; hit_idx_q <= scan_idx;
					end
					if (!valid_q[scan_idx] && !free_q) begin
						free_q <= 1'b1; free_idx_q <= scan_idx;
					end
					if (scan_q == CNT_W'(ENTRIES - 1)) state_q <= S_DECIDE;
					scan_q <= scan_q + CNT_W'(1);
				end
				S_DECIDE: begin
					row_ok_q <= 1'b0;
					state_q <= S_FINISH;
					if (!cmd_q) begin
						if (hit_q) begin
							row_q <= hit_idx_q; row_ok_q <= 1'b1;
							st_q <= ST_UPDATED; state_q <= S_COST;
						end else if (!free_q) st_q <= ST_FULL;
						else if (rssi_q < good_min_q) st_q <= ST_LOW_RSSI;
						else begin
							row_q <= free_idx_q; row_ok_q <= 1'b1;
							st_q <= ST_ADDED; state_q <= S_COST;
							valid_q[free_idx_q] <= 1'b1;
						end
					end else if (bcast_q) st_q <= ST_BCAST;
					else if (!hit_q) st_q <= ST_NOT_FOUND;
					else begin
						row_q <= hit_idx_q; row_ok_q <= 1'b1;
						st_q <= ST_UPDATED; state_q <= S_COST;
					end
				end
				default: ;
			endcase

			// Apply the row update in the first cost cycle, then compute cost
			if (state_q == S_COST) begin
				if (st_q == ST_ADDED) begin
					addr_q[row_q] <= ev_addr_q; insec_q[row_q] <= insecure_q;
					stable_q[row_q] <= 1'b1; stab_cnt_q[row_q] <= 8'd0;
					last_rssi_q[row_q] <= rssi_q; rx_q[row_q] <= 8'd1;
					tx_q[row_q] <= 8'd0; ack_q[row_q] <= 8'd0; wrap_q[row_q] <= 8'd0;
					black_q[row_q] <= 1'b0; heard_q[row_q] <= ts_q;
					jp_q[row_q] <= jpp_q ? jp_in_q : def_jp_q;
					tx_r_q <= 8'd0; ack_r_q <= 8'd0;
				end else if (!cmd_q) begin
					insec_q[row_q] <= insecure_q; rx_q[row_q] <= rx_q[row_q] + 8'd1;
					last_rssi_q[row_q] <= rssi_q; heard_q[row_q] <= ts_q;
					if (jpp_q) jp_q[row_q] <= jp_in_q;
					if (flip_cond) begin
						if (cnt_inc >= stab_thr_q) begin
							stab_cnt_q[row_q] <= 8'd0;
							stable_q[row_q] <= !stable_q[row_q];
						end else stab_cnt_q[row_q] <= cnt_inc;
					end else stab_cnt_q[row_q] <= 8'd0;
					tx_r_q <= tx_cur; ack_r_q <= ack_cur;
				end else begin
					if (txsum[8]) begin
						wrap_q[row_q] <= wrap_q[row_q] + 8'd1;
						tx_r_q <= (tx_cur >> 1) + att_q;
						ack_r_q <= (ack_cur >> 1) + {7'd0, acked_q};
					end else begin
						tx_r_q <= txsum[7:0];
						ack_r_q <= ack_cur + {7'd0, acked_q};
					end
					if (acked_q) heard_q[row_q] <= ts_q;
				end
				state_q <= S_MUL1;
			end else if (state_q == S_MUL1) begin
				// Store counters, form default cost on the shared multiplier
				tx_q[row_q] <= tx_r_q; ack_q[row_q] <= ack_r_q;
				dflt_q <= (dlc_q == 6'd0) ? -$signed({20'd0, mhri_q, 1'b0}) :
					$signed(mul_p);
				state_q <= S_MUL2;
			end else if (state_q == S_MUL2) begin
				// Form the no-ack cost or the product for the division
				state_q <= S_DIV;
				if (ack_r_q != 8'd0) prod_q <= mul_p;
				else if (tx_r_q <= {2'd0, dlc_q}) prod_q <= dflt_q[31] ? 32'd0 : dflt_q;
				else if (tx_r_q >= min_tx_q) prod_q <= 32'hFFFF;
				else prod_q <= mul_p;
			end else if (state_q == S_DIV) begin
				if (ack_r_q == 8'd0) begin
					state_q <= S_FINISH;
					link_cost <= (prod_q > 32'hFFFF) ? 16'hFFFF : prod_q[15:0];
				end else begin
					dreq.start <= 1'b1;
					dreq.dividend <= {prod_q[29:0], 10'd0};
					dreq.divisor <= ack_r_q;
					sub_q <= {18'd0, mhri_q, 11'd0};
					state_q <= S_DIVWAIT;
				end
			end else if (state_q == S_DIVWAIT) begin
				if (ddone) begin
					state_q <= S_FINISH;
					link_cost <= div_cost;
					if ($signed({1'b0, div_cost}) > dflt_q && tx_r_q > min_tx_q)
						black_q[row_q] <= 1'b1;
				end
			end else if (state_q == S_FINISH) begin
				// Present the result for one cycle
				done <= 1'b1;
				status <= st_q;
				state_q <= S_IDLE;
				if (row_ok_q) begin
					entry_index <= 5'(row_q);
					entry_stable <= stable_q[row_q];
					entry_blacklisted <= black_q[row_q];
					tx_count_out <= tx_r_q;
					ack_count_out <= ack_r_q;
				end else begin
					entry_index <= '0; entry_stable <= 1'b0; entry_blacklisted <= 1'b0;
					tx_count_out <= '0; ack_count_out <= '0; link_cost <= '0;
				end
			end
		end
	end

	logic unused;
	assign unused = ^{wrap_q[0], last_rssi_q[0], heard_q[0], jp_q[0], insec_q};
endmodule
`default_nettype wire

FILE: sv/nlst_checker.sv
// Port checker for the neighbour link statistics table, with its bind.
// Depends on neighbor_link_stats_table_assert.svh.
`default_nettype none
`include "neighbor_link_stats_table_assert.svh"
module nlst_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic cfg_ready,
	input wire logic done,
	input wire logic [2:0] status,
	input wire logic [4:0] entry_index,
	input wire logic [15:0] link_cost
);
	`NLST_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`NLST_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`NLST_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_ready, !busy)
	`NLST_ASSERT_IMP(a_status_range, clk, arst_n, done, status <= 3'd5)
	`NLST_ASSERT_IMP(a_no_row_zero, clk, arst_n, done && status >= 3'd2,
		entry_index == 5'd0 && link_cost == 16'd0)
endmodule
bind neighbor_link_stats_table nlst_checker u_chk (.*);
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for neighbor_link_stats_table.
// Depends on nlst_pkg and the table RTL; predicts each event result in SV.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import nlst_pkg::*;

	localparam int WDOG_LIMIT = 4000;
	localparam int N_ROWS = ENTRIES;

	typedef struct {
		logic        cmd;
		logic [63:0] addr;
		logic [7:0]  rssi;
		logic [39:0] ts;
		logic        jp_present;
		logic [7:0]  jp;
		logic        insecure;
		logic [7:0]  attempts;
		logic        acked;
		logic        bcast;
	} nb_event_t;

	typedef struct {
		status_t     status;
		logic [4:0]  index;
		logic        stable;
		logic [15:0] cost;
		logic        black;
		logic [7:0]  tx;
		logic [7:0]  ack;
	} nb_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cmd = 1'b0;
	logic [63:0] addr = '0;
	logic signed [7:0] rssi = '0;
	logic [39:0] timestamp = '0;
	logic join_prio_present = 1'b0;
	logic [7:0] join_prio = '0;
	logic insecure = 1'b0;
	logic [7:0] tx_attempts = '0;
	logic acked = 1'b0;
	logic is_broadcast = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [10:0] cfg_data = '0;
	logic done;
	logic [2:0] status;
	logic [4:0] entry_index;
	logic entry_stable;
	logic [15:0] link_cost;
	logic entry_blacklisted;
	logic [7:0] tx_count_out;
	logic [7:0] ack_count_out;

	neighbor_link_stats_table i_dut (.*);

	always #2 clk = ~clk;

	// Shadow configuration and table
	logic [7:0] bad_max, good_min, stab_thr, min_tx, def_jp;
	logic [10:0] mhri;
	logic [5:0] dlc;
	logic        row_valid [N_ROWS];
	logic [63:0] row_addr [N_ROWS];
	logic        row_stable [N_ROWS];
	logic [7:0]  row_stab_cnt [N_ROWS];
	logic [7:0]  row_rx [N_ROWS];
	logic [7:0]  row_tx [N_ROWS];
	logic [7:0]  row_ack [N_ROWS];
	logic        row_black [N_ROWS];

	nb_event_t  pending_events[$];
	nb_report_t expected_reports[$];
	int n_errors = 0;
	int idle_pct = 0;
	int wdog = 0;
	logic [63:0] known_addr[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
		n_errors++;
	endtask

	function automatic logic [15:0] cost_of_row(input int k);
		longint dflt, q, sub, d;
		logic [15:0] c;
		dflt = (3 * longint'(dlc) - 2) * longint'(mhri);
		if (row_ack[k] == 0) begin
			if (row_tx[k] > dlc) begin
				if (row_tx[k] < min_tx) begin
					d = (3 * longint'(row_tx[k]) - 2) * longint'(mhri);
					c = (d > 65535) ? 16'hffff : d[15:0];
				end else begin
					c = 16'hffff;
				end
			end else begin
				c = (dflt < 0) ? 16'd0 : (dflt > 65535) ? 16'hffff : dflt[15:0];
			end
		end else begin
			q = ((longint'(row_tx[k]) << 10) * 3 * longint'(mhri)) / longint'(row_ack[k]);
			sub = (longint'(mhri) * 2) << 10;
			if (q < sub) begin
				c = 16'd0;
			end else begin
				d = q - sub;
				c = (d >= (longint'(65536) << 10)) ? 16'hffff : d[25:10];
			end
			if (longint'(c) > dflt && row_tx[k] > min_tx)
				row_black[k] = 1'b1;
		end
		return c;
	endfunction

	// Apply one event to the shadow table and queue its report
	function automatic void predict_event(input nb_event_t ev);
		nb_report_t r;
		int row;
		row = -1;
		for (int k = 0; k < N_ROWS; k++)
			if (row < 0 && row_valid[k] && row_addr[k] == ev.addr) row = k;
		if (!ev.cmd) begin
			if (row >= 0) begin
				row_rx[row] = row_rx[row] + 8'd1;
				if (row_stable[row] ? ($signed(ev.rssi) < $signed(good_min))
						: ($signed(ev.rssi) > $signed(bad_max))) begin
					row_stab_cnt[row] = row_stab_cnt[row] + 8'd1;
					if (row_stab_cnt[row] >= stab_thr) begin
						row_stab_cnt[row] = 0;
						row_stable[row] = ~row_stable[row];
					end
				end else begin
					row_stab_cnt[row] = 0;
				end
				r.status = ST_UPDATED;
			end else begin
				r.status = ST_FULL;
				for (int k = 0; k < N_ROWS; k++) begin
					if (r.status == ST_FULL && !row_valid[k]) begin
						if ($signed(ev.rssi) < $signed(good_min)) begin
							r.status = ST_LOW_RSSI;
						end else begin
							row_valid[k] = 1'b1;
							row_addr[k] = ev.addr;
							row_stable[k] = 1'b1;
							row_stab_cnt[k] = 0;
							row_rx[k] = 8'd1;
							row_tx[k] = 0;
							row_ack[k] = 0;
							row_black[k] = 1'b0;
							row = k;
							r.status = ST_ADDED;
						end
					end
				end
			end
		end else if (ev.bcast) begin
			r.status = ST_BCAST;
			row = -1;
		end else if (row < 0) begin
			r.status = ST_NOT_FOUND;
		end else begin
			if (int'(row_tx[row]) > 255 - int'(ev.attempts)) begin
				row_tx[row] = row_tx[row] >> 1;
				row_ack[row] = row_ack[row] >> 1;
			end
			row_tx[row] = row_tx[row] + ev.attempts;
			if (ev.acked) row_ack[row] = row_ack[row] + 8'd1;
			r.status = ST_UPDATED;
		end
		r.index = '0; r.stable = 0; r.cost = '0; r.black = 0; r.tx = '0; r.ack = '0;
		if (row >= 0) begin
			r.cost = cost_of_row(row);
			r.index = row[4:0];
			r.stable = row_stable[row];
			r.black = row_black[row];
			r.tx = row_tx[row];
			r.ack = row_ack[row];
		end
		expected_reports.push_back(r);
	endfunction

	function automatic nb_event_t random_event();
		nb_event_t ev;
		ev.cmd = 1'($urandom_range(0, 1));
		// Mostly reuse known neighbours so updates dominate
		if (known_addr.size() > 0 && $urandom_range(0, 9) < 8)
			ev.addr = known_addr[$urandom_range(0, known_addr.size() - 1)];
		else
			ev.addr = {$urandom, $urandom};
		if (!ev.cmd && known_addr.size() < 40) known_addr.push_back(ev.addr);
		ev.rssi = 8'($urandom);
		ev.ts = 40'({$urandom, $urandom});
		ev.jp_present = 1'($urandom_range(0, 1));
		ev.jp = 8'($urandom);
		ev.insecure = 1'($urandom_range(0, 1));
		ev.attempts = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 20)) : 8'($urandom);
		ev.acked = 1'($urandom_range(0, 1));
		ev.bcast = ($urandom_range(0, 9) == 0);
		return ev;
	endfunction

	function automatic nb_event_t make_event(input logic c, input logic [63:0] a,
			input logic [7:0] rs, input logic [7:0] att, input logic ak, input logic bc);
		nb_event_t ev;
		ev.cmd = c; ev.addr = a; ev.rssi = rs; ev.ts = 40'({$urandom, $urandom});
		ev.jp_present = 1'($urandom_range(0, 1)); ev.jp = 8'($urandom);
		ev.insecure = 1'($urandom_range(0, 1)); ev.attempts = att; ev.acked = ak;
		ev.bcast = bc;
		return ev;
	endfunction

	// Accept flag sampled at the rising edge
	logic busy_q = 1'b1;
	always @(posedge clk) busy_q <= busy;

	// Driver: present the next event at the falling edge, hold until taken
	always @(negedge clk) begin
		if (start && !busy_q) begin
			start <= 1'b0;
		end else if (!start && pending_events.size() > 0 && !cfg_valid
				&& $urandom_range(0, 99) >= idle_pct) begin
			nb_event_t ev;
			ev = pending_events.pop_front();
			cmd <= ev.cmd; addr <= ev.addr; rssi <= ev.rssi; timestamp <= ev.ts;
			join_prio_present <= ev.jp_present; join_prio <= ev.jp;
			insecure <= ev.insecure; tx_attempts <= ev.attempts; acked <= ev.acked;
			is_broadcast <= ev.bcast;
			predict_event(ev);
			start <= 1'b1;
		end
	end

	// Monitor: compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) wdog <= 0;
			else wdog <= wdog + 1;
			if (done) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("unexpected result", 64'(status), 64'd0);
				end else begin
					nb_report_t r;
					r = expected_reports.pop_front();
					if (status != r.status)
						report_mismatch("status", 64'(status), 64'(r.status));
					if (entry_index != r.index)
						report_mismatch("index", 64'(entry_index), 64'(r.index));
					if (entry_stable != r.stable)
						report_mismatch("stable", 64'(entry_stable), 64'(r.stable));
					if (link_cost != r.cost)
						report_mismatch("link_cost", 64'(link_cost), 64'(r.cost));
					if (entry_blacklisted != r.black)
						report_mismatch("blacklisted", 64'(entry_blacklisted), 64'(r.black));
					if (tx_count_out != r.tx)
						report_mismatch("tx_count", 64'(tx_count_out), 64'(r.tx));
					if (ack_count_out != r.ack)
						report_mismatch("ack_count", 64'(ack_count_out), 64'(r.ack));
				end
			end
			if (wdog >= WDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_events.size() > 0 || expected_reports.size() > 0 || start)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [10:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_BAD_MAX_RSSI:  bad_max = val[7:0];
			REG_GOOD_MIN_RSSI: good_min = val[7:0];
			REG_STAB_THR:      stab_thr = val[7:0];
			REG_MHRI:          mhri = val;
			REG_DLC:           dlc = val[5:0];
			REG_MIN_TX:        min_tx = val[7:0];
			REG_DEF_JP:        def_jp = val[7:0];
			default:           ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input int bmr, input int gmr, input int thr,
			input int mh, input int dc, input int mt, input int jp);
		write_reg(REG_BAD_MAX_RSSI, 11'(bmr & 8'hff));
		write_reg(REG_GOOD_MIN_RSSI, 11'(gmr & 8'hff));
		write_reg(REG_STAB_THR, 11'(thr));
		write_reg(REG_MHRI, 11'(mh));
		write_reg(REG_DLC, 11'(dc));
		write_reg(REG_MIN_TX, 11'(mt));
		write_reg(REG_DEF_JP, 11'(jp));
	endtask

	task automatic run_random(input int n, input int pct);
		idle_pct = pct;
		for (int i = 0; i < n; i++) pending_events.push_back(random_event());
		wait_drained();
	endtask

	initial begin
		bad_max = -8'sd70; good_min = -8'sd90; stab_thr = 3; mhri = 256;
		dlc = 15; min_tx = 16; def_jp = 255;
		for (int k = 0; k < N_ROWS; k++) begin
			row_valid[k] = 0; row_addr[k] = 0; row_stable[k] = 0; row_stab_cnt[k] = 0;
			row_rx[k] = 0; row_tx[k] = 0; row_ack[k] = 0; row_black[k] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: low rssi, add, stability, transmit wrap, broadcast, not found
		pending_events.push_back(make_event(1'b0, 64'hffff_ffff_ffff_ffff, 8'h80,
			8'd0, 1'b0, 1'b0));
		pending_events.push_back(make_event(1'b0, 64'hffff_ffff_ffff_ffff, 8'h7f,
			8'd0, 1'b0, 1'b0));
		pending_events.push_back(make_event(1'b0, 64'h0, 8'hb0, 8'd0, 1'b0, 1'b0));
		for (int i = 0; i < 4; i++)
			pending_events.push_back(make_event(1'b0, 64'h0, 8'h80, 8'd0, 1'b0, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'h0, 8'd0, 8'd255, 1'b1, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'h0, 8'd0, 8'd255, 1'b0, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'h0, 8'd0, 8'd0, 1'b1, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'hffff_ffff_ffff_ffff, 8'd0,
			8'd20, 1'b0, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'hffff_ffff_ffff_ffff, 8'd0,
			8'd3, 1'b1, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'h0, 8'd0, 8'd1, 1'b1, 1'b1));
		pending_events.push_back(make_event(1'b1, 64'h1234, 8'd0, 8'd1, 1'b1, 1'b0));
		// Fill the table until it reports full
		for (int i = 0; i < 32; i++)
			pending_events.push_back(make_event(1'b0, 64'h100 + i, 8'h7f, 8'd0,
				1'b0, 1'b0));
		wait_drained();

		// Seed the address pool with rows already in the table
		known_addr.push_back(64'h0);
		known_addr.push_back(64'hffff_ffff_ffff_ffff);
		for (int i = 0; i < 30; i++) known_addr.push_back(64'h100 + i);

		// Extremes of configuration, including zero threshold
		set_config(127, -128, 0, 1024, 63, 255, 0);
		pending_events.push_back(make_event(1'b0, 64'h0, 8'h80, 8'd0, 1'b0, 1'b0));
		pending_events.push_back(make_event(1'b1, 64'h0, 8'd0, 8'd200, 1'b1, 1'b0));
		wait_drained();
		set_config(-128, 127, 255, 1, 1, 0, 255);
		run_random(150, 0);
		set_config(-70, -90, 3, 256, 15, 16, 255);
		run_random(150, 51);
		set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 6),
				$urandom_range(1, 1024), $urandom_range(1, 63), $urandom_range(0, 40),
				$urandom_range(0, 255));
		run_random(150, 31);
		set_config(-60, -95, 2, 2047, 5, 8, 7);
		run_random(150, 0);

		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
